### hdl/assert_macros.svh
// Assertion helpers; every check runs on clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds on every clock edge outside reset.
`define LPMR_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that cons holds on any clock edge where ante holds.
`define LPMR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after any clock edge where ante holds.
`define LPMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/lpmr_pkg.sv
package lpmr_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MARK    = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SKIP    = 3'd3,
    PH_CLOSED  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_REGISTERED = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_BAD_REG    = 3'd2,
    ST_BAD_LEN    = 3'd3,
    ST_SHORT      = 3'd4,
    ST_NO_TARGET  = 3'd5,
    ST_RESET      = 3'd6
  } status_t;

  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_RESET = 1'b1;
  localparam logic KIND_FWD   = 1'b0;
  localparam logic KIND_STAT  = 1'b1;

  localparam logic [15:0] MAX_LEN_RESET = 16'd65532;

  // Per-slot parse context held in the state memory
  typedef struct packed {
    phase_t      phase;
    logic [15:0] byte_cnt;
    logic [31:0] pkt_len;
    logic [63:0] mark_sh;
  } entry_t;

  localparam entry_t ENTRY_CLEAR = '{phase: PH_HEADER, byte_cnt: 16'd0,
                                     pkt_len: 32'd0, mark_sh: 64'd0};

  typedef struct packed {
    logic        kind;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [7:0]  data;
    logic        eop;
    status_t     status;
    logic        last;
  } res_t;

  function automatic res_t make_report(logic [1:0] src, status_t st);
    res_t r;
    r = '{kind: KIND_STAT, src: src, dst: 2'd0, data: 8'd0, eop: 1'b0,
          status: st, last: 1'b0};
    return r;
  endfunction

  function automatic res_t make_fwd(logic [1:0] src, logic [1:0] dst,
                                    logic [7:0] data, logic eop);
    res_t r;
    r = '{kind: KIND_FWD, src: src, dst: dst, data: data, eop: eop,
          status: ST_REGISTERED, last: 1'b0};
    return r;
  endfunction

endpackage

### hdl/length_prefixed_mark_relay_top.sv
// Channel | Direction | Beat contents
// in_     | input     | func, conn_slot, byte (one stream byte or a slot reset)
// out_    | output    | kind, src/dst slot, byte, end_of_packet, status, last
// cfg_    | input     | max_packet_len write, taken on the cycle of cfg_wr_en
//
// One input beat per cycle while in_ready is high: stage 0 reads the slot context
// memory, stage 1 decides and writes it back (forwarding covers the same slot
// twice). Each beat yields 0..4 results into a 16-entry output queue drained at
// one per cycle while out_ready is high; in_ready drops while the queue holds more than 8 results.
// Reset (rst_n low, synchronous) clears the per-slot valid bits, so every slot
// reads as fresh; the queue empties and max_packet_len returns to 65532.
`include "assert_macros.svh"

module length_prefixed_mark_relay_top #(
  parameter int NUM_SLOTS  = 4,
  parameter int MARK_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [1:0]  in_conn_slot,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [1:0]  out_src_slot,
  output logic [1:0]  out_dst_slot,
  output logic [7:0]  out_byte,
  output logic        out_end_of_packet,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QDEPTH = 16;
  localparam logic [63:0] MMASK = {64{1'b1}} >> (64 - 8 * MARK_BYTES);
  localparam logic [15:0] MB16 = 16'(MARK_BYTES);

  logic [15:0] max_len_r;

  // slot context memories
  lpmr_pkg::entry_t mem_r [NUM_SLOTS];
  logic [SW-1:0]    tgt_mem_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;

  // mark table, searched in parallel
  logic [63:0]          own_mark_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] is_reg_r;

  // stage 1
  logic             s1_valid_r;
  logic             s1_func_r;
  logic [SW-1:0]    s1_slot_r;
  logic [1:0]       s1_src_r;
  logic [7:0]       s1_byte_r;
  lpmr_pkg::entry_t rd_ent_r;
  logic [SW-1:0]    rd_tgt_r;
  logic             rd_vld_r;
  logic             fwd_r;
  lpmr_pkg::entry_t wb_ent_r;
  logic [SW-1:0]    wb_tgt_r;

  // output queue
  lpmr_pkg::res_t fifo_r [QDEPTH];
  logic [3:0] head_r, tail_r;
  logic [4:0] count_r;

  logic in_acc, in_range, pop;
  logic [SW-1:0] in_slot;

  lpmr_pkg::entry_t ent, ent_nxt;
  logic [SW-1:0] tgt, tgt_nxt;
  lpmr_pkg::res_t res [4];
  logic [2:0] n_res, push_n;
  logic reg_set, reg_clr;
  logic [63:0] mark_val;
  logic hit;
  logic [SW-1:0] hit_idx;
  logic [1:0] c_idx;
  logic [31:0] len_asm;
  logic [15:0] cnt_inc, plen16;

  assign in_slot  = SW'(in_conn_slot);
  assign in_range = 32'(in_conn_slot) < NUM_SLOTS;
  assign in_ready = count_r <= 5'(QDEPTH - 8);
  assign in_acc   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lpmr_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Stage 0: read the slot context, note whether stage 1 overwrites it now
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= in_acc && in_range;
      fwd_r      <= s1_valid_r && (s1_slot_r == in_slot);
    end
    if (in_acc) begin
      rd_ent_r  <= mem_r[in_slot];
      rd_tgt_r  <= tgt_mem_r[in_slot];
      rd_vld_r  <= vld_r[in_slot];
      s1_func_r <= in_func;
      s1_slot_r <= in_slot;
      s1_src_r  <= in_conn_slot;
      s1_byte_r <= in_byte;
    end
  end

  // Mark search, lowest slot wins
  always_comb begin
    mark_val = (({ent.mark_sh[55:0], 8'h00}) | 64'(s1_byte_r)) & MMASK;
    hit      = 1'b0;
    hit_idx  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (is_reg_r[i] && own_mark_r[i] == mark_val) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
    end
  end

  // Stage 1: decide on the beat and build the new context
  always_comb begin
    ent = fwd_r ? wb_ent_r : (rd_vld_r ? rd_ent_r : lpmr_pkg::ENTRY_CLEAR);
    tgt = fwd_r ? wb_tgt_r : (rd_vld_r ? rd_tgt_r : '0);
    ent_nxt = ent;
    tgt_nxt = tgt;
    n_res   = 3'd0;
    reg_set = 1'b0;
    reg_clr = 1'b0;
    for (int k = 0; k < 4; k++) res[k] = lpmr_pkg::make_report(s1_src_r,
                                                  lpmr_pkg::ST_REGISTERED);
    c_idx   = ent.byte_cnt[1:0];
    len_asm = ((c_idx == 2'd0) ? 32'd0 : ent.pkt_len) | (32'(s1_byte_r) << {c_idx, 3'b000});
    cnt_inc = ent.byte_cnt + 16'd1;
    plen16  = 16'(ent.pkt_len - 32'(MARK_BYTES));

    if (s1_func_r == lpmr_pkg::FUNC_RESET) begin
      ent_nxt = lpmr_pkg::ENTRY_CLEAR;
      tgt_nxt = '0;
      reg_clr = 1'b1;
      res[0]  = lpmr_pkg::make_report(s1_src_r, lpmr_pkg::ST_RESET);
      n_res   = 3'd1;
    end else begin
      unique case (ent.phase)
        lpmr_pkg::PH_HEADER: begin
          ent_nxt.pkt_len = len_asm;
          if (c_idx != 2'd3) begin
            ent_nxt.byte_cnt = 16'(c_idx) + 16'd1;
          end else begin
            ent_nxt.byte_cnt = 16'd0;
            ent_nxt.mark_sh  = 64'd0;
            if (len_asm == 32'd0 || len_asm > 32'(max_len_r)) begin
              ent_nxt.phase = lpmr_pkg::PH_CLOSED;
              reg_clr = 1'b1;
              res[0]  = lpmr_pkg::make_report(s1_src_r, lpmr_pkg::ST_BAD_LEN);
              n_res   = 3'd1;
            end else if (!is_reg_r[s1_slot_r]) begin
              if (len_asm != 32'(MARK_BYTES)) begin
                ent_nxt.phase = lpmr_pkg::PH_CLOSED;
                res[0] = lpmr_pkg::make_report(s1_src_r, lpmr_pkg::ST_BAD_REG);
                n_res  = 3'd1;
              end else begin
                ent_nxt.phase = lpmr_pkg::PH_MARK;
              end
            end else if (len_asm < 32'(MARK_BYTES)) begin
              ent_nxt.phase    = lpmr_pkg::PH_SKIP;
              ent_nxt.byte_cnt = len_asm[15:0];
              res[0] = lpmr_pkg::make_report(s1_src_r, lpmr_pkg::ST_SHORT);
              n_res  = 3'd1;
            end else begin
              ent_nxt.phase = lpmr_pkg::PH_MARK;
            end
          end
        end
        lpmr_pkg::PH_MARK: begin
          ent_nxt.mark_sh  = mark_val;
          ent_nxt.byte_cnt = cnt_inc;
          if (cnt_inc >= MB16) begin
            if (!is_reg_r[s1_slot_r]) begin
              ent_nxt.byte_cnt = 16'd0;
              if (hit) begin
                ent_nxt.phase = lpmr_pkg::PH_CLOSED;
                res[0] = lpmr_pkg::make_report(s1_src_r, lpmr_pkg::ST_DUPLICATE);
              end else begin
                ent_nxt.phase = lpmr_pkg::PH_HEADER;
                reg_set = 1'b1;
                res[0] = lpmr_pkg::make_report(s1_src_r, lpmr_pkg::ST_REGISTERED);
              end
              n_res = 3'd1;
            end else if (!hit) begin
              res[0] = lpmr_pkg::make_report(s1_src_r, lpmr_pkg::ST_NO_TARGET);
              n_res  = 3'd1;
              ent_nxt.phase    = (plen16 != 16'd0) ? lpmr_pkg::PH_SKIP : lpmr_pkg::PH_HEADER;
              ent_nxt.byte_cnt = plen16;
            end else if (plen16 == 16'd0) begin
              ent_nxt.phase    = lpmr_pkg::PH_HEADER;
              ent_nxt.byte_cnt = 16'd0;
            end else begin
              tgt_nxt = hit_idx;
              // fresh little-endian length header ahead of the payload
              res[0] = lpmr_pkg::make_fwd(s1_src_r, 2'(hit_idx), plen16[7:0], 1'b0);
              res[1] = lpmr_pkg::make_fwd(s1_src_r, 2'(hit_idx), plen16[15:8], 1'b0);
              res[2] = lpmr_pkg::make_fwd(s1_src_r, 2'(hit_idx), 8'd0, 1'b0);
              res[3] = lpmr_pkg::make_fwd(s1_src_r, 2'(hit_idx), 8'd0, 1'b0);
              n_res = 3'd4;
              ent_nxt.phase    = lpmr_pkg::PH_PAYLOAD;
              ent_nxt.byte_cnt = plen16;
            end
          end
        end
        lpmr_pkg::PH_PAYLOAD: begin
          res[0] = lpmr_pkg::make_fwd(s1_src_r, 2'(tgt), s1_byte_r, ent.byte_cnt <= 16'd1);
          n_res  = 3'd1;
          if (ent.byte_cnt <= 16'd1) begin
            ent_nxt.phase    = lpmr_pkg::PH_HEADER;
            ent_nxt.byte_cnt = 16'd0;
          end else begin
            ent_nxt.byte_cnt = ent.byte_cnt - 16'd1;
          end
        end
        lpmr_pkg::PH_SKIP: begin
          if (ent.byte_cnt <= 16'd1) begin
            ent_nxt.phase    = lpmr_pkg::PH_HEADER;
            ent_nxt.byte_cnt = 16'd0;
          end else begin
            ent_nxt.byte_cnt = ent.byte_cnt - 16'd1;
          end
        end
        default: begin
          // closed: hold until a slot reset
        end
      endcase
      if (ent_nxt.phase == lpmr_pkg::PH_CLOSED && ent.phase != lpmr_pkg::PH_CLOSED) begin
        reg_clr = 1'b1;
      end
    end
    for (int k = 0; k < 4; k++) res[k].last = (3'(k + 1) == n_res);
  end

  assign push_n = s1_valid_r ? n_res : 3'd0;

  // Write back the context and the mark table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      is_reg_r <= '0;
    end else if (s1_valid_r) begin
      vld_r[s1_slot_r] <= 1'b1;
      if (reg_clr) is_reg_r[s1_slot_r] <= 1'b0;
      if (reg_set) is_reg_r[s1_slot_r] <= 1'b1;
    end
    if (s1_valid_r) begin
      mem_r[s1_slot_r]     <= ent_nxt;
      tgt_mem_r[s1_slot_r] <= tgt_nxt;
      wb_ent_r <= ent_nxt;
      wb_tgt_r <= tgt_nxt;
      if (reg_set) own_mark_r[s1_slot_r] <= mark_val;
    end
  end

  // Output queue: push up to four beats, pop one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 4'd0;
      tail_r  <= 4'd0;
      count_r <= 5'd0;
    end else begin
      head_r  <= head_r + 4'(pop);
      tail_r  <= tail_r + 4'(push_n);
      count_r <= count_r + 5'(push_n) - 5'(pop);
    end
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < push_n) fifo_r[tail_r + 4'(k)] <= res[k];
    end
  end

  assign out_valid         = count_r != 5'd0;
  assign out_kind          = fifo_r[head_r].kind;
  assign out_src_slot      = fifo_r[head_r].src;
  assign out_dst_slot      = fifo_r[head_r].dst;
  assign out_byte          = fifo_r[head_r].data;
  assign out_end_of_packet = fifo_r[head_r].eop;
  assign out_status        = fifo_r[head_r].status;
  assign out_last          = fifo_r[head_r].last;

  `LPMR_ASSERT_ALWAYS(a_queue_bound, count_r <= 5'(QDEPTH))
  `LPMR_ASSERT_IMPL(a_room_for_push, s1_valid_r, (count_r + 5'(n_res)) <= 5'(QDEPTH))
  `LPMR_ASSERT_IMPL(a_no_reg_and_clear, s1_valid_r, !(reg_set && reg_clr))
  `LPMR_ASSERT_NEXT(a_reset_reports, in_acc && in_range && in_func == lpmr_pkg::FUNC_RESET,
                    s1_valid_r && n_res == 3'd1)

endmodule

### tb/tb_length_prefixed_mark_relay_top.sv
`timescale 1ns / 1ps

// One stream beat toward the relay: a data byte or a slot reset.
typedef struct {
  logic       func;
  logic [1:0] slot;
  logic [7:0] data;
} relay_beat_t;

class relay_scoreboard;
  lpmr_pkg::res_t   pending[$];
  int               mismatches;
  int               checked;
  logic [15:0]      max_len;
  lpmr_pkg::phase_t ph[4];
  logic [15:0]      cnt[4];
  logic [31:0]      plen[4];
  logic [63:0]      shift_mark[4];
  logic [63:0]      own[4];
  bit               owned[4];
  logic [1:0]       tgt[4];

  function void clear_all();
    max_len = lpmr_pkg::MAX_LEN_RESET;
    pending.delete();
    for (int i = 0; i < 4; i++) wipe(i);
  endfunction

  function void wipe(int s);
    ph[s] = lpmr_pkg::PH_HEADER;
    cnt[s] = '0;
    plen[s] = '0;
    shift_mark[s] = '0;
    own[s] = '0;
    owned[s] = 0;
    tgt[s] = '0;
  endfunction

  function void shut(int s);
    ph[s] = lpmr_pkg::PH_CLOSED;
    owned[s] = 0;
    cnt[s] = '0;
  endfunction

  function int owner_of(logic [63:0] m);
    for (int i = 0; i < 4; i++)
      if (owned[i] && own[i] == m) return i;
    return -1;
  endfunction

  function lpmr_pkg::res_t status_res(int s, lpmr_pkg::status_t st);
    lpmr_pkg::res_t r;
    r = '{kind: lpmr_pkg::KIND_STAT, src: s[1:0], dst: 2'd0, data: 8'd0, eop: 1'b0,
          status: st, last: 1'b0};
    return r;
  endfunction

  function lpmr_pkg::res_t fwd_res(int s, logic [1:0] d, logic [7:0] b, logic e);
    lpmr_pkg::res_t r;
    r = '{kind: lpmr_pkg::KIND_FWD, src: s[1:0], dst: d, data: b, eop: e,
          status: lpmr_pkg::ST_REGISTERED, last: 1'b0};
    return r;
  endfunction

  // Predict what one accepted beat produces and queue it.
  function void note_beat(relay_beat_t bt);
    lpmr_pkg::res_t fresh[$];
    int             s;
    int             c;
    int             t;
    logic [31:0]    len;
    logic [63:0]    m;
    logic [15:0]    pl;
    s = bt.slot;
    if (bt.func == lpmr_pkg::FUNC_RESET) begin
      wipe(s);
      fresh.push_back(status_res(s, lpmr_pkg::ST_RESET));
    end else begin
      case (ph[s])
        lpmr_pkg::PH_HEADER: begin
          c = cnt[s][1:0];
          plen[s] = (c == 0 ? 32'd0 : plen[s]) | (32'(bt.data) << (8 * c));
          if (c < 3) begin
            cnt[s] = 16'(c + 1);
          end else begin
            len = plen[s];
            cnt[s] = '0;
            shift_mark[s] = '0;
            if (len == 0 || len > max_len) begin
              shut(s);
              fresh.push_back(status_res(s, lpmr_pkg::ST_BAD_LEN));
            end else if (!owned[s]) begin
              if (len != 8) begin
                shut(s);
                fresh.push_back(status_res(s, lpmr_pkg::ST_BAD_REG));
              end else begin
                ph[s] = lpmr_pkg::PH_MARK;
              end
            end else if (len < 8) begin
              ph[s] = lpmr_pkg::PH_SKIP;
              cnt[s] = len[15:0];
              fresh.push_back(status_res(s, lpmr_pkg::ST_SHORT));
            end else begin
              ph[s] = lpmr_pkg::PH_MARK;
            end
          end
        end
        lpmr_pkg::PH_MARK: begin
          m = {shift_mark[s][55:0], bt.data};
          shift_mark[s] = m;
          cnt[s] = cnt[s] + 16'd1;
          if (cnt[s] >= 8) begin
            t = owner_of(m);
            if (!owned[s]) begin
              if (t >= 0) begin
                shut(s);
                fresh.push_back(status_res(s, lpmr_pkg::ST_DUPLICATE));
              end else begin
                own[s] = m;
                owned[s] = 1;
                ph[s] = lpmr_pkg::PH_HEADER;
                cnt[s] = '0;
                fresh.push_back(status_res(s, lpmr_pkg::ST_REGISTERED));
              end
            end else begin
              pl = 16'(plen[s] - 32'd8);
              if (t < 0) begin
                fresh.push_back(status_res(s, lpmr_pkg::ST_NO_TARGET));
                ph[s] = (pl != 0) ? lpmr_pkg::PH_SKIP : lpmr_pkg::PH_HEADER;
                cnt[s] = pl;
              end else if (pl == 0) begin
                ph[s] = lpmr_pkg::PH_HEADER;
                cnt[s] = '0;
              end else begin
                tgt[s] = t[1:0];
                fresh.push_back(fwd_res(s, tgt[s], pl[7:0], 1'b0));
                fresh.push_back(fwd_res(s, tgt[s], pl[15:8], 1'b0));
                fresh.push_back(fwd_res(s, tgt[s], 8'd0, 1'b0));
                fresh.push_back(fwd_res(s, tgt[s], 8'd0, 1'b0));
                ph[s] = lpmr_pkg::PH_PAYLOAD;
                cnt[s] = pl;
              end
            end
          end
        end
        lpmr_pkg::PH_PAYLOAD: begin
          fresh.push_back(fwd_res(s, tgt[s], bt.data, cnt[s] <= 1));
          if (cnt[s] <= 1) begin
            ph[s] = lpmr_pkg::PH_HEADER;
            cnt[s] = '0;
          end else begin
            cnt[s] = cnt[s] - 16'd1;
          end
        end
        lpmr_pkg::PH_SKIP: begin
          if (cnt[s] <= 1) begin
            ph[s] = lpmr_pkg::PH_HEADER;
            cnt[s] = '0;
          end else begin
            cnt[s] = cnt[s] - 16'd1;
          end
        end
        default: ;
      endcase
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) pending.push_back(fresh[i]);
  endfunction

  task flag(string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Compare one delivered result against the oldest prediction.
  task check_beat(lpmr_pkg::res_t got);
    lpmr_pkg::res_t want;
    checked++;
    if (pending.size() == 0) begin
      flag($sformatf("unexpected result %p", got));
      return;
    end
    want = pending.pop_front();
    if (got.kind !== want.kind || got.src !== want.src || got.dst !== want.dst ||
        got.data !== want.data || got.eop !== want.eop ||
        got.status !== want.status || got.last !== want.last)
      flag($sformatf("got %p want %p", got, want));
  endtask
endclass

module tb_length_prefixed_mark_relay_top;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [1:0]  in_conn_slot;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [1:0]  out_src_slot;
  logic [1:0]  out_dst_slot;
  logic [7:0]  out_byte;
  logic        out_end_of_packet;
  logic [2:0]  out_status;
  logic        out_last;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  relay_scoreboard relay_sb;
  relay_beat_t     stream_q[$];   // beats in send order
  relay_beat_t     lane[4][$];    // per-slot beats, merged into stream_q
  logic [63:0]     mark_pool[6];
  int              send_idle_pct;
  int              recv_stall_pct;
  int              hold_left;     // long receiver hold-off, counted down per cycle
  int              cycles;
  int              beats_sent;
  int              cfg_writes;

  length_prefixed_mark_relay_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_conn_slot      (in_conn_slot),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_src_slot      (out_src_slot),
    .out_dst_slot      (out_dst_slot),
    .out_byte          (out_byte),
    .out_end_of_packet (out_end_of_packet),
    .out_status        (out_status),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: give up if the run stalls far beyond its slowest legal length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check every accepted beat, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      relay_sb.check_beat('{kind: out_kind, src: out_src_slot, dst: out_dst_slot,
                            data: out_byte, eop: out_end_of_packet,
                            status: lpmr_pkg::status_t'(out_status), last: out_last});
    if (hold_left > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Count the long hold-off down, one cycle at a time.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Stimulus building: queue beats per slot, then interleave lanes at random.
  function automatic void add_beat(logic f, int s, logic [7:0] b);
    relay_beat_t bt;
    bt.func = f;
    bt.slot = s[1:0];
    bt.data = b;
    lane[s].push_back(bt);
  endfunction

  function automatic void add_len(int s, logic [31:0] len);
    for (int k = 0; k < 4; k++) add_beat(lpmr_pkg::FUNC_DATA, s, len[8 * k +: 8]);
  endfunction

  // Marks go out high byte first, so they shift in as written.
  function automatic void add_mark(int s, logic [63:0] m);
    for (int k = 7; k >= 0; k--) add_beat(lpmr_pkg::FUNC_DATA, s, m[8 * k +: 8]);
  endfunction

  function automatic void add_packet(int s, logic [63:0] m, int pay);
    add_len(s, 32'(8 + pay));
    add_mark(s, m);
    for (int k = 0; k < pay; k++) add_beat(lpmr_pkg::FUNC_DATA, s, 8'($urandom));
  endfunction

  function automatic void merge_lanes();
    int pick;
    while (lane[0].size() + lane[1].size() + lane[2].size() + lane[3].size() > 0) begin
      pick = $urandom_range(0, 3);
      if (lane[pick].size() > 0) stream_q.push_back(lane[pick].pop_front());
    end
  endfunction

  task automatic send_stream();
    relay_beat_t bt;
    while (stream_q.size() > 0) begin
      bt = stream_q.pop_front();
      // Idle gaps land between beats only, never inside a held offer.
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_func      <= bt.func;
      in_conn_slot <= bt.slot;
      in_byte      <= bt.data;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      relay_sb.note_beat(bt);
      beats_sent++;
    end
    in_valid <= 1'b0;
  endtask

  // Drain all predictions, then cover beats still in the pipe that yield nothing.
  task automatic wait_quiet();
    while (relay_sb.pending.size() > 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_max_len(logic [15:0] v);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    relay_sb.max_len = v;
    cfg_writes++;
  endtask

  // A few random packets from the two registered slots, now and then short.
  task automatic random_round(int n_pkts, int max_pay);
    int s;
    int len;
    for (int n = 0; n < n_pkts; n++) begin
      s = $urandom_range(0, 1);
      if ($urandom_range(0, 3) != 0) begin
        add_packet(s, mark_pool[$urandom_range(0, 4)], $urandom_range(0, max_pay));
      end else begin
        len = $urandom_range(1, 7);
        add_len(s, 32'(len));
        for (int j = 0; j < len; j++) add_beat(lpmr_pkg::FUNC_DATA, s, 8'($urandom));
      end
    end
    merge_lanes();
    send_stream();
  endtask

  initial begin
    relay_sb = new();
    relay_sb.clear_all();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = lpmr_pkg::FUNC_DATA;
    in_conn_slot   = 2'd0;
    in_byte        = 8'd0;
    out_ready      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 16'd0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    cycles         = 0;
    beats_sent     = 0;
    cfg_writes     = 0;
    mark_pool[0] = '1;
    mark_pool[1] = '0;
    for (int i = 2; i < 6; i++) mark_pool[i] = {$urandom, $urandom};
    mark_pool[5][0] = ~mark_pool[4][0];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, no idling: registration, duplicates, bad lengths, closed slots,
    // the target branches and a target reset in the middle of a payload.
    for (int s = 0; s < 4; s++) add_beat(lpmr_pkg::FUNC_RESET, s, 8'hFF);
    add_packet(0, mark_pool[2], 0);                // register slot 0
    merge_lanes();
    add_packet(1, mark_pool[3], 0);                // register slot 1
    merge_lanes();
    add_packet(2, mark_pool[2], 0);                // duplicate mark closes slot 2
    merge_lanes();
    add_beat(lpmr_pkg::FUNC_DATA, 2, 8'hA5);       // closed slot ignores data
    add_beat(lpmr_pkg::FUNC_RESET, 2, 8'h00);
    add_len(2, 32'd5);                             // bad registration length
    add_len(3, 32'd0);                             // zero length
    merge_lanes();
    add_beat(lpmr_pkg::FUNC_RESET, 3, 8'h00);
    add_len(3, 32'd65533);                         // just above the limit
    merge_lanes();
    add_packet(0, mark_pool[3], 0);                // found target, empty payload
    add_len(0, 32'd3);                             // short packet, skipped
    for (int j = 0; j < 3; j++) add_beat(lpmr_pkg::FUNC_DATA, 0, 8'h00);
    add_packet(0, mark_pool[5], 1);                // unknown target, skip payload
    add_len(0, 32'd11);                            // forward 0 -> 1, target resets
    add_mark(0, mark_pool[3]);
    add_beat(lpmr_pkg::FUNC_DATA, 0, 8'h00);
    merge_lanes();
    add_beat(lpmr_pkg::FUNC_RESET, 1, 8'h00);
    merge_lanes();
    add_beat(lpmr_pkg::FUNC_DATA, 0, 8'h5A);
    add_beat(lpmr_pkg::FUNC_DATA, 0, 8'hC3);
    merge_lanes();
    send_stream();

    // Bring slot 1 back so both slots trade traffic.
    write_max_len(16'd65532);
    add_packet(1, mark_pool[3], 0);
    merge_lanes();
    send_stream();

    // Sender idling.
    send_idle_pct = 47;
    write_max_len(16'd65535);
    random_round(1, 4);

    // Receiver stalling, with a long hold-off so the output queue fills.
    send_idle_pct = 0;
    recv_stall_pct = 47;
    write_max_len(16'd20);
    hold_left = 300;
    add_packet(0, mark_pool[3], 10);
    merge_lanes();
    send_stream();

    // Both sides idling, with a tight length limit.
    send_idle_pct = 34;
    recv_stall_pct = 34;
    write_max_len(16'd9);
    random_round(1, 3);

    wait_quiet();
    $display("relay run: %0d input beats, %0d results checked, %0d limit writes",
             beats_sent, relay_sb.checked, cfg_writes);
    $display("covered registration, forwarding, drops, closes and resets on 4 slots");
    if (relay_sb.mismatches == 0 && relay_sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hdl
hdl/lpmr_pkg.sv
hdl/length_prefixed_mark_relay_top.sv
tb/tb_length_prefixed_mark_relay_top.sv
